### src/rv64ie_pkg.sv
// ----------------------------------------------------------------------------
// rv64ie_pkg: shared types and constants for the RV64I integer execute core
// Operation codes, register file geometry and instruction field positions.
// ----------------------------------------------------------------------------
package rv64ie_pkg;

  localparam int unsigned XLEN       = 64;
  localparam int unsigned NUM_REGS   = 32;
  localparam int unsigned REG_AW     = 5;
  localparam int unsigned KIND_W     = 5;
  localparam int unsigned INSN_W     = 32;

  typedef logic [XLEN-1:0]   xword_t;
  typedef logic [REG_AW-1:0] reg_idx_t;

  // Operation selected by the kind field. Codes 30 and 31 carry no operation.
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 5'd0,
    KIND_SUB   = 5'd1,
    KIND_SLL   = 5'd2,
    KIND_SLT   = 5'd3,
    KIND_SLTU  = 5'd4,
    KIND_XOR   = 5'd5,
    KIND_SRL   = 5'd6,
    KIND_SRA   = 5'd7,
    KIND_OR    = 5'd8,
    KIND_AND   = 5'd9,
    KIND_ADDW  = 5'd10,
    KIND_SUBW  = 5'd11,
    KIND_SLLW  = 5'd12,
    KIND_SRLW  = 5'd13,
    KIND_SRAW  = 5'd14,
    KIND_ADDI  = 5'd15,
    KIND_SLTI  = 5'd16,
    KIND_SLTIU = 5'd17,
    KIND_XORI  = 5'd18,
    KIND_ORI   = 5'd19,
    KIND_ANDI  = 5'd20,
    KIND_SLLI  = 5'd21,
    KIND_SRLI  = 5'd22,
    KIND_SRAI  = 5'd23,
    KIND_ADDIW = 5'd24,
    KIND_SLLIW = 5'd25,
    KIND_SRLIW = 5'd26,
    KIND_SRAIW = 5'd27,
    KIND_LUI   = 5'd28,
    KIND_AUIPC = 5'd29
  } kind_e;

  // Sign-extend the low 32 bits of a word to the full register width.
  function automatic xword_t sext32(input logic [31:0] v);
    sext32 = {{(XLEN-32){v[31]}}, v};
  endfunction

endpackage

### src/rv64i_integer_execute_core.sv
// An accepted word passes the input stage, then the result stage; operand read, ALU and
// writeback share one stage. Throughput: one word per cycle while results are taken.
// The 32 x 64-bit register file is a one-write, two-read memory with registered reads.
// Reset clears the pipeline valids and all register file valid bits at once, so every
// register reads as zero after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
// rv64i_integer_execute_core: RV64I register and immediate ALU with register file
// Decodes rd, rs1, rs2 and immediates, computes the result, writes it back to the
// register file and reports the destination and the value written.
// ----------------------------------------------------------------------------
module rv64i_integer_execute_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  kind_i,
  input  logic [31:0] insn_i,
  input  logic [63:0] pc_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  dest_reg_o,
  output logic [63:0] write_value_o
);

  // --------------------------------------------------------------------------
  // Handshake and stage control.
  // The result register frees up when it is empty or its word is taken. The
  // input stage advances whenever the result register is free, and a new word
  // can enter the input stage in the same cycle that the old one leaves, so
  // the core sustains one word per cycle.
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_move;
  logic in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input stage payload. The source registers are read from the memory on the
  // same edge that captures the word.
  // --------------------------------------------------------------------------
  logic [4:0]  kind_q;
  logic [31:0] insn_q;
  logic [63:0] pc_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_i;
      insn_q <= insn_i;
      pc_q   <= pc_i;
    end
  end

  // --------------------------------------------------------------------------
  // Register file. Data lives in a memory with no reset; a valid bit per
  // entry, cleared by reset, makes an entry that was never written read as
  // zero. Entry zero is never written, so x0 always reads as zero.
  // A write to a source register on the capture edge is forwarded, because
  // the registered memory read still returns the older contents.
  // --------------------------------------------------------------------------
  rv64ie_pkg::xword_t   rf_mem [rv64ie_pkg::NUM_REGS];
  logic [rv64ie_pkg::NUM_REGS-1:0] rf_vld_q;

  logic                 wr_en;
  rv64ie_pkg::reg_idx_t wr_addr;
  rv64ie_pkg::xword_t   wr_data;

  rv64ie_pkg::reg_idx_t in_rs1;
  rv64ie_pkg::reg_idx_t in_rs2;

  rv64ie_pkg::xword_t rd_a_q;
  rv64ie_pkg::xword_t rd_b_q;
  rv64ie_pkg::xword_t fwd_q;
  logic               a_fwd_q;
  logic               b_fwd_q;
  logic               a_vld_q;
  logic               b_vld_q;

  assign in_rs1 = insn_i[19:15];
  assign in_rs2 = insn_i[24:20];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rf_mem[wr_addr] <= wr_data;
    end
    if (in_accept) begin
      rd_a_q <= rf_mem[in_rs1];
      rd_b_q <= rf_mem[in_rs2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (wr_en) begin
      rf_vld_q[wr_addr] <= 1'b1;
    end
  end

  // Forwarding and valid flags travel with the captured word.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_q   <= wr_data;
      a_fwd_q <= wr_en && (wr_addr == in_rs1);
      b_fwd_q <= wr_en && (wr_addr == in_rs2);
      a_vld_q <= rf_vld_q[in_rs1];
      b_vld_q <= rf_vld_q[in_rs2];
    end
  end

  rv64ie_pkg::xword_t op_a;
  rv64ie_pkg::xword_t op_b;

  assign op_a = a_fwd_q ? fwd_q : (a_vld_q ? rd_a_q : '0);
  assign op_b = b_fwd_q ? fwd_q : (b_vld_q ? rd_b_q : '0);

  // --------------------------------------------------------------------------
  // Decode and execute.
  // --------------------------------------------------------------------------
  rv64ie_pkg::reg_idx_t rd_idx;
  rv64ie_pkg::xword_t   imm_i;
  rv64ie_pkg::xword_t   imm_u;
  logic [5:0]           sh_r6;
  logic [4:0]           sh_r5;
  logic [5:0]           sh_i6;
  logic [4:0]           sh_i5;
  logic [31:0]          a_lo;

  assign rd_idx = insn_q[11:7];
  assign imm_i  = {{52{insn_q[31]}}, insn_q[31:20]};
  assign imm_u  = {{32{insn_q[31]}}, insn_q[31:12], 12'h000};
  assign sh_r6  = op_b[5:0];
  assign sh_r5  = op_b[4:0];
  assign sh_i6  = insn_q[25:20];
  assign sh_i5  = insn_q[24:20];
  assign a_lo   = op_a[31:0];

  rv64ie_pkg::xword_t result;
  logic               res_wr;
  logic [31:0]        sum32;

  always_comb begin
    result = '0;
    res_wr = 1'b1;
    sum32  = '0;
    unique case (rv64ie_pkg::kind_e'(kind_q))
      rv64ie_pkg::KIND_ADD:   result = op_a + op_b;
      rv64ie_pkg::KIND_SUB:   result = op_a - op_b;
      rv64ie_pkg::KIND_SLL:   result = op_a << sh_r6;
      rv64ie_pkg::KIND_SLT:   result = {63'd0, $signed(op_a) < $signed(op_b)};
      rv64ie_pkg::KIND_SLTU:  result = {63'd0, op_a < op_b};
      rv64ie_pkg::KIND_XOR:   result = op_a ^ op_b;
      rv64ie_pkg::KIND_SRL:   result = op_a >> sh_r6;
      rv64ie_pkg::KIND_SRA:   result = $signed(op_a) >>> sh_r6;
      rv64ie_pkg::KIND_OR:    result = op_a | op_b;
      rv64ie_pkg::KIND_AND:   result = op_a & op_b;
      rv64ie_pkg::KIND_ADDW: begin
        sum32  = a_lo + op_b[31:0];
        result = rv64ie_pkg::sext32(sum32);
      end
      rv64ie_pkg::KIND_SUBW: begin
        sum32  = a_lo - op_b[31:0];
        result = rv64ie_pkg::sext32(sum32);
      end
      rv64ie_pkg::KIND_SLLW:  result = rv64ie_pkg::sext32(a_lo << sh_r5);
      rv64ie_pkg::KIND_SRLW:  result = rv64ie_pkg::sext32(a_lo >> sh_r5);
      rv64ie_pkg::KIND_SRAW:  result = rv64ie_pkg::sext32($signed(a_lo) >>> sh_r5);
      rv64ie_pkg::KIND_ADDI:  result = op_a + imm_i;
      rv64ie_pkg::KIND_SLTI:  result = {63'd0, $signed(op_a) < $signed(imm_i)};
      rv64ie_pkg::KIND_SLTIU: result = {63'd0, op_a < imm_i};
      rv64ie_pkg::KIND_XORI:  result = op_a ^ imm_i;
      rv64ie_pkg::KIND_ORI:   result = op_a | imm_i;
      rv64ie_pkg::KIND_ANDI:  result = op_a & imm_i;
      rv64ie_pkg::KIND_SLLI:  result = op_a << sh_i6;
      rv64ie_pkg::KIND_SRLI:  result = op_a >> sh_i6;
      rv64ie_pkg::KIND_SRAI:  result = $signed(op_a) >>> sh_i6;
      rv64ie_pkg::KIND_ADDIW: begin
        sum32  = a_lo + imm_i[31:0];
        result = rv64ie_pkg::sext32(sum32);
      end
      rv64ie_pkg::KIND_SLLIW: result = rv64ie_pkg::sext32(a_lo << sh_i5);
      rv64ie_pkg::KIND_SRLIW: result = rv64ie_pkg::sext32(a_lo >> sh_i5);
      rv64ie_pkg::KIND_SRAIW: result = rv64ie_pkg::sext32($signed(a_lo) >>> sh_i5);
      rv64ie_pkg::KIND_LUI:   result = imm_u;
      rv64ie_pkg::KIND_AUIPC: result = pc_q + imm_u;
      default: begin
        // Unused operation codes report zero and leave the registers alone.
        result = '0;
        res_wr = 1'b0;
      end
    endcase
  end

  // Writeback happens as the word leaves the input stage; a write to x0 is dropped.
  assign wr_en   = s1_move && res_wr && (rd_idx != '0);
  assign wr_addr = rd_idx;
  assign wr_data = result;

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  rv64ie_pkg::reg_idx_t dest_q;
  rv64ie_pkg::xword_t   value_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      dest_q  <= rd_idx;
      value_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dest_reg_o    = dest_q;
  assign write_value_o = value_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input stage");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr != '0))
    else $error("register file write to x0");

  a_move_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("word left the input stage but no result was presented");

  a_x0_never_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> !rf_vld_q[0])
    else $error("x0 entry marked as written");

endmodule

### dv/rv64i_integer_execute_core_tb.sv
// ----------------------------------------------------------------------------
// rv64i_integer_execute_core_tb: self-checking testbench for the RV64I execute core
// Drives a directed table and then random instruction words through the core.
// Every result is checked against a shadow register file and an ALU predictor, or a
// typed-in value for directed rows. Both sides throttle at random, and the run includes
// one long result back-pressure stretch and two full drains.
// ----------------------------------------------------------------------------
module rv64i_integer_execute_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int BURST_WORDS  = 30;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  // Kind codes with no operation behind them; the core reports zero and writes nothing.
  localparam logic [rv64ie_pkg::KIND_W-1:0] KIND_UNUSED_LO = 5'd30;
  localparam logic [rv64ie_pkg::KIND_W-1:0] KIND_UNUSED_HI = 5'd31;

  typedef struct {
    logic [rv64ie_pkg::KIND_W-1:0] kind;
    logic [rv64ie_pkg::INSN_W-1:0] insn;
    rv64ie_pkg::xword_t            pc;
    bit                            lit_en;   // expected value typed in below
    rv64ie_pkg::xword_t            lit;
  } stim_row_t;

  typedef struct {
    rv64ie_pkg::reg_idx_t rd;
    rv64ie_pkg::xword_t   value;
  } writeback_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [rv64ie_pkg::KIND_W-1:0] kind = '0;
  logic [rv64ie_pkg::INSN_W-1:0] insn = '0;
  rv64ie_pkg::xword_t            pc = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  rv64ie_pkg::reg_idx_t          dest_reg;
  rv64ie_pkg::xword_t            write_value;

  // Directed rows carry their typed-in expectation next to the payload.
  bit                            drv_lit_en = 1'b0;
  rv64ie_pkg::xword_t            drv_lit = '0;

  // Shadow of the architectural register file and the results still owed by the core.
  rv64ie_pkg::xword_t            gpr_shadow [rv64ie_pkg::NUM_REGS];
  writeback_t                    writeback_q [$];
  stim_row_t                     directed_q [$];

  bit                            rx_idle = 1'b0;   // result side stalls at random when set
  bit                            hold_req = 1'b0;  // asks the result side for one long hold-off
  bit                            hold_on = 1'b0;   // set while that hold-off is running
  rv64ie_pkg::reg_idx_t          prev_rd = '0;
  int                            fail_cnt = 0;
  int                            words_in = 0;
  int                            results_seen = 0;
  int                            cycle_cnt = 0;

  rv64i_integer_execute_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .insn_i        (insn),
    .pc_i          (pc),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .dest_reg_o    (dest_reg),
    .write_value_o (write_value)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[rv64i_integer_execute_core] ERROR");
      $finish;
    end
  end

  // Instruction word builders. Only the register and immediate fields matter to the
  // core, but the opcode bits are filled in so the words read naturally in a trace.
  function automatic logic [31:0] r_word(input int rd, input int rs1, input int rs2);
    return {7'b0, 5'(rs2), 5'(rs1), 3'b0, 5'(rd), 7'b0110011};
  endfunction

  function automatic logic [31:0] i_word(input int rd, input int rs1,
                                         input logic [11:0] imm);
    return {imm, 5'(rs1), 3'b0, 5'(rd), 7'b0010011};
  endfunction

  function automatic logic [31:0] u_word(input int rd, input logic [19:0] imm);
    return {imm, 5'(rd), 7'b0110111};
  endfunction

  function automatic rv64ie_pkg::xword_t widen32(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  // Computes the value the core must write back for one instruction, reading the
  // shadow register file. Register x0 always reads as zero.
  function automatic rv64ie_pkg::xword_t execute_insn(
      input logic [rv64ie_pkg::KIND_W-1:0] op,
      input logic [rv64ie_pkg::INSN_W-1:0] iw, input rv64ie_pkg::xword_t addr);
    rv64ie_pkg::xword_t a;
    rv64ie_pkg::xword_t b;
    rv64ie_pkg::xword_t imm_i;
    rv64ie_pkg::xword_t imm_u;
    rv64ie_pkg::xword_t res;
    a     = (iw[19:15] == '0) ? '0 : gpr_shadow[iw[19:15]];
    b     = (iw[24:20] == '0) ? '0 : gpr_shadow[iw[24:20]];
    imm_i = {{52{iw[31]}}, iw[31:20]};
    imm_u = {{32{iw[31]}}, iw[31:12], 12'h000};
    case (op)
      rv64ie_pkg::KIND_ADD:   res = a + b;
      rv64ie_pkg::KIND_SUB:   res = a - b;
      rv64ie_pkg::KIND_SLL:   res = a << b[5:0];
      rv64ie_pkg::KIND_SLT:   res = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
      rv64ie_pkg::KIND_SLTU:  res = (a < b) ? 64'd1 : 64'd0;
      rv64ie_pkg::KIND_XOR:   res = a ^ b;
      rv64ie_pkg::KIND_SRL:   res = a >> b[5:0];
      rv64ie_pkg::KIND_SRA:   res = $signed(a) >>> b[5:0];
      rv64ie_pkg::KIND_OR:    res = a | b;
      rv64ie_pkg::KIND_AND:   res = a & b;
      // The W forms work on the low 32 bits and sign-extend the 32-bit result.
      rv64ie_pkg::KIND_ADDW:  res = widen32(a[31:0] + b[31:0]);
      rv64ie_pkg::KIND_SUBW:  res = widen32(a[31:0] - b[31:0]);
      rv64ie_pkg::KIND_SLLW:  res = widen32(a[31:0] << b[4:0]);
      rv64ie_pkg::KIND_SRLW:  res = widen32(a[31:0] >> b[4:0]);
      rv64ie_pkg::KIND_SRAW:  res = widen32($signed(a[31:0]) >>> b[4:0]);
      rv64ie_pkg::KIND_ADDI:  res = a + imm_i;
      rv64ie_pkg::KIND_SLTI:  res = ($signed(a) < $signed(imm_i)) ? 64'd1 : 64'd0;
      rv64ie_pkg::KIND_SLTIU: res = (a < imm_i) ? 64'd1 : 64'd0;
      rv64ie_pkg::KIND_XORI:  res = a ^ imm_i;
      rv64ie_pkg::KIND_ORI:   res = a | imm_i;
      rv64ie_pkg::KIND_ANDI:  res = a & imm_i;
      // Immediate shifts take the shift amount from the low immediate bits only.
      rv64ie_pkg::KIND_SLLI:  res = a << imm_i[5:0];
      rv64ie_pkg::KIND_SRLI:  res = a >> imm_i[5:0];
      rv64ie_pkg::KIND_SRAI:  res = $signed(a) >>> imm_i[5:0];
      rv64ie_pkg::KIND_ADDIW: res = widen32(a[31:0] + imm_i[31:0]);
      rv64ie_pkg::KIND_SLLIW: res = widen32(a[31:0] << imm_i[4:0]);
      rv64ie_pkg::KIND_SRLIW: res = widen32(a[31:0] >> imm_i[4:0]);
      rv64ie_pkg::KIND_SRAIW: res = widen32($signed(a[31:0]) >>> imm_i[4:0]);
      rv64ie_pkg::KIND_LUI:   res = imm_u;
      rv64ie_pkg::KIND_AUIPC: res = addr + imm_u;
      default:                res = '0;
    endcase
    return res;
  endfunction

  // Scoreboard. All stimulus is driven with nonblocking assignments, so the values
  // seen here at the edge are the ones the core sampled at that same edge.
  always @(posedge clk) begin
    writeback_t         wb;
    rv64ie_pkg::xword_t v;
    if (rst_n && in_valid && !in_stall) begin
      v = execute_insn(kind, insn, pc);
      wb.rd    = insn[11:7];
      wb.value = drv_lit_en ? drv_lit : v;
      writeback_q.push_back(wb);
      // Unused kinds and writes to x0 leave the register file untouched.
      if (kind < KIND_UNUSED_LO && insn[11:7] != '0) gpr_shadow[insn[11:7]] = v;
      words_in++;
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      results_seen++;
      if (writeback_q.size() == 0) begin
        $error("result with nothing expected: dest_reg %0d, write_value %h",
               dest_reg, write_value);
        fail_cnt++;
      end else begin
        wb = writeback_q.pop_front();
        if (dest_reg !== wb.rd) begin
          $error("dest_reg mismatch: expected %0d, got %0d", wb.rd, dest_reg);
          fail_cnt++;
        end
        if (write_value !== wb.value) begin
          $error("write_value mismatch: expected %h, got %h", wb.value, write_value);
          fail_cnt++;
        end
      end
    end
  end

  // Result side. Runs of stall and no stall, mostly short with a few long ones,
  // plus one long hold-off on request that lets the core fill and stall its input.
  initial begin
    int run;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_on = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        hold_on  = 1'b0;
      end else if (!rx_idle) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (run) @(posedge clk);
      end
    end
  end

  // Offers one word and returns at the edge where it is taken. The caller is always
  // at a rising edge, so valid stays high across back-to-back words.
  task automatic send_word(input logic [rv64ie_pkg::KIND_W-1:0] k,
                           input logic [rv64ie_pkg::INSN_W-1:0] iw,
                           input rv64ie_pkg::xword_t addr, input bit lit_en,
                           input rv64ie_pkg::xword_t lit);
    in_valid   <= 1'b1;
    kind       <= k;
    insn       <= iw;
    pc         <= addr;
    drv_lit_en <= lit_en;
    drv_lit    <= lit;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic idle_gap(input bit enable);
    int n;
    n = 0;
    if (enable) n = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (writeback_q.size() != 0) @(posedge clk);
  endtask

  // Random words: the source registers often point at the last destination so that
  // results chain through the register file, and the immediate sometimes sits at a
  // corner. A small share uses the unused kinds.
  task automatic run_random(input int count, input bit gaps);
    logic [rv64ie_pkg::KIND_W-1:0] k;
    logic [rv64ie_pkg::INSN_W-1:0] iw;
    rv64ie_pkg::xword_t            addr;
    repeat (count) begin
      k  = ($urandom_range(0, 19) == 0)
           ? 5'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI))
           : 5'($urandom_range(rv64ie_pkg::KIND_ADD, rv64ie_pkg::KIND_AUIPC));
      iw = $urandom;
      if ($urandom_range(0, 1) == 0) iw[19:15] = prev_rd;
      if ($urandom_range(0, 2) == 0) iw[24:20] = prev_rd;
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       iw[31:20] = 12'h800;
          1:       iw[31:20] = 12'h7ff;
          2:       iw[31:20] = 12'hfff;
          default: iw[31:20] = 12'h000;
        endcase
      end
      addr = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) addr = ($urandom_range(0, 1) == 0) ? '1 : '0;
      prev_rd = iw[11:7];
      send_word(k, iw, addr, 1'b0, '0);
      idle_gap(gaps);
    end
  endtask

  initial begin
    // Directed table. The first rows set x1 = -1, x2 = 0x7ff, x3 = 0xffffffff80000000,
    // and the later rows exercise every operation but OR, mostly on those corner values.
    directed_q = '{
      '{rv64ie_pkg::KIND_ADD,   r_word(1, 0, 0),        '0, 1'b1, 64'h0},
      '{rv64ie_pkg::KIND_ADDI,  i_word(1, 0, 12'hfff),  '0, 1'b1, 64'hffff_ffff_ffff_ffff},
      '{rv64ie_pkg::KIND_ORI,   i_word(2, 0, 12'h7ff),  '0, 1'b1, 64'h0000_0000_0000_07ff},
      '{rv64ie_pkg::KIND_LUI,   u_word(3, 20'h80000),   '0, 1'b1, 64'hffff_ffff_8000_0000},
      // auipc at the top of the address space wraps around
      '{rv64ie_pkg::KIND_AUIPC, u_word(4, 20'h00001),   '1, 1'b1, 64'h0000_0000_0000_0fff},
      // a write to x0 is reported but dropped, so x0 still reads as zero next
      '{rv64ie_pkg::KIND_ADDI,  i_word(0, 0, 12'h005),  '0, 1'b1, 64'h0000_0000_0000_0005},
      '{rv64ie_pkg::KIND_ADD,   r_word(5, 0, 0),        '0, 1'b1, 64'h0},
      // unused kinds report zero and must not disturb x6 or x1
      '{KIND_UNUSED_LO,         r_word(6, 1, 1),        '0, 1'b1, 64'h0},
      '{KIND_UNUSED_HI,         r_word(1, 2, 3),        '0, 1'b1, 64'h0},
      '{rv64ie_pkg::KIND_SUB,   r_word(7, 0, 1),        '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SLL,   r_word(8, 1, 2),        '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SLT,   r_word(9, 3, 2),        '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SLTU,  r_word(10, 3, 2),       '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_XOR,   r_word(11, 3, 1),       '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SRL,   r_word(12, 3, 2),       '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SRA,   r_word(13, 3, 2),       '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_AND,   r_word(14, 3, 4),       '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_ADDW,  r_word(15, 3, 3),       '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SUBW,  r_word(16, 0, 3),       '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SLLW,  r_word(17, 1, 2),       '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SRLW,  r_word(18, 3, 2),       '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SRAW,  r_word(19, 3, 2),       '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SLTI,  i_word(20, 3, 12'hfff), '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SLTIU, i_word(21, 3, 12'hfff), '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_XORI,  i_word(22, 1, 12'h800), '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_ANDI,  i_word(23, 3, 12'h800), '0, 1'b0, '0},
      // upper immediate bits above the shift amount are ignored
      '{rv64ie_pkg::KIND_SLLI,  i_word(24, 1, 12'hfff), '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SRLI,  i_word(25, 3, 12'h03f), '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SRAI,  i_word(26, 3, 12'h43f), '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_ADDIW, i_word(27, 3, 12'hfff), '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SLLIW, i_word(28, 1, 12'h01f), '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SRLIW, i_word(29, 3, 12'h01f), '0, 1'b0, '0},
      '{rv64ie_pkg::KIND_SRAIW, i_word(30, 3, 12'h3ff), '0, 1'b0, '0}
    };
    foreach (gpr_shadow[i]) gpr_shadow[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) begin
      send_word(directed_q[i].kind, directed_q[i].insn, directed_q[i].pc,
                directed_q[i].lit_en, directed_q[i].lit);
    end

    // Random words with both sides throttling.
    rx_idle = 1'b1;
    run_random(300, 1'b1);

    // Long hold-off on the result side while words keep coming, then a full drain
    // with the input idle. The burst starts only once the hold-off is in force.
    in_valid <= 1'b0;
    hold_req = 1'b1;
    do @(posedge clk); while (!hold_on);
    run_random(BURST_WORDS, 1'b0);
    in_valid <= 1'b0;
    @(posedge clk);
    drain_results();

    // A stretch at full rate in both directions, then throttling again.
    rx_idle = 1'b0;
    run_random(150, 1'b0);
    rx_idle = 1'b1;
    run_random(170, 1'b1);

    in_valid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (writeback_q.size() != 0) begin
      $error("%0d results never arrived", writeback_q.size());
      fail_cnt++;
    end

    $display("Sent %0d words (%0d from the directed table) over all 30 operations and",
             words_in, directed_q.size());
    $display("both unused kinds; %0d results compared, %0d failures.", results_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("[rv64i_integer_execute_core] OK");
    end else begin
      $display("[rv64i_integer_execute_core] ERROR");
    end
    $finish;
  end

endmodule
